>>> rtl/grc_pkg.sv
// grc_pkg: shared constants and types for grid_raycast_column
// no dependencies
`timescale 1ns / 1ps
package grc_pkg;
  localparam int MAP_SIZE = 64;
  localparam int MAP_BITS = $clog2(MAP_SIZE);
  localparam int TEX_SIZE = 64;
  localparam int TEX_BITS = $clog2(TEX_SIZE);
  localparam int MAX_VIEW = 1024;
  localparam int MAP_DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int ADDR_BITS = 2 * MAP_BITS;
  localparam int WALK_MAX = 2 * MAP_SIZE + 2;
  localparam int FIFO_DEPTH = 2;

  localparam logic [2:0] REG_POS_X = 3'd0;
  localparam logic [2:0] REG_POS_Y = 3'd1;
  localparam logic [2:0] REG_DIR_X = 3'd2;
  localparam logic [2:0] REG_DIR_Y = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_VIEW_W = 3'd6;
  localparam logic [2:0] REG_VIEW_H = 3'd7;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [7:0] tile_in;
    logic [9:0] column;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        side;
    logic [7:0]  tile_out;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic [23:0] distance;
    logic [9:0]  wall_height;
    logic [9:0]  first_row;
    logic [9:0]  last_row;
    logic [5:0]  tex_column;
  } out_item_t;

  // work handed from the front part to the back part
  typedef struct packed {
    logic        is_cast;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]  tile;
    logic [9:0]  column;
  } job_t;
endpackage

>>> rtl/grc_if.sv
// grc_if: valid/ready channel interfaces for items, results and register writes
// depends on grc_pkg
`timescale 1ns / 1ps
interface grc_in_if import grc_pkg::*; (input logic clk);
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface grc_out_if import grc_pkg::*; (input logic clk);
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface grc_cfg_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/grc_ram.sv
// grc_ram: generic single-port write, single read RAM with registered read
// no dependencies
`timescale 1ns / 1ps
module grc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/grc_div.sv
// grc_div: radix-2 restoring unsigned divider, one quotient bit per cycle
// depends on nothing but its ports; 48-bit numerator, 28-bit divisor
`timescale 1ns / 1ps
module grc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] num,
  input  logic [27:0] den,
  output logic        done,
  output logic [47:0] quo,
  output logic [27:0] rem
);
  logic [47:0] q;
  logic [28:0] r;
  logic [5:0]  cnt;
  logic        busy;
  logic [27:0] den_q;
  logic [28:0] r_shift;
  logic [28:0] r_sub;

  // one shift and trial subtract per cycle
  always_comb begin
    r_shift = {r[27:0], q[47]};
    r_sub   = r_shift - {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        q     <= num;
        r     <= '0;
        den_q <= den;
        cnt   <= 6'd48;
      end else if (busy) begin
        if (!r_sub[28]) begin
          r <= r_sub;
          q <= {q[46:0], 1'b1};
        end else begin
          r <= r_shift;
          q <= {q[46:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
  assign rem = r[27:0];
endmodule

>>> rtl/grc_front.sv
// grc_front: accepts input beats, classifies them and queues jobs for the back part
// depends on grc_pkg
`timescale 1ns / 1ps
module grc_front import grc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_take,
  output job_t     job
);
  job_t        q [FIFO_DEPTH];
  logic        wp;
  logic        rp;
  logic [1:0]  cnt;
  logic        push;
  job_t        new_job;

  assign in_ready  = (cnt != 2'(FIFO_DEPTH));
  assign push      = in_valid && in_ready;
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rp];

  // classify the incoming beat
  always_comb begin
    new_job.is_cast = (in_data.mode == MODE_CAST);
    new_job.addr    = {in_data.cell_y[MAP_BITS-1:0], in_data.cell_x[MAP_BITS-1:0]};
    new_job.tile    = in_data.tile_in;
    new_job.column  = in_data.column;
  end

  // two-entry job queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) begin
        q[wp] <= new_job;
        wp    <= ~wp;
      end
      if (job_take) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, job_take};
    end
  end
endmodule

>>> rtl/grc_back.sv
// grc_back: map store with clearing pass, column setup, dda walk and wall results
// depends on grc_pkg, grc_ram, grc_div
`timescale 1ns / 1ps
module grc_back import grc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_take,
  input  job_t               job,
  input  logic [15:0]        pos_x,
  input  logic [15:0]        pos_y,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] plane_x,
  input  logic signed [15:0] plane_y,
  input  logic [10:0]        view_w,
  input  logic [10:0]        view_h,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAM, S_CAMW, S_RAY, S_RAYB, S_DLX, S_DLXW, S_DLY, S_DLYW,
    S_SD, S_SDB, S_STEP, S_READ, S_CHECK, S_DIST, S_DISTW, S_HGT, S_HGTW,
    S_TEX, S_TEXW, S_ROWS, S_OUT
  } state_t;

  state_t state;
  logic [ADDR_BITS:0] clr_cnt;

  // ram ports
  logic                 ram_we;
  logic [ADDR_BITS-1:0] ram_waddr;
  logic [7:0]           ram_wdata;
  logic [ADDR_BITS-1:0] ram_raddr;
  logic [7:0]           ram_rdata;

  grc_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // shared divider
  logic        dv_start;
  logic [47:0] dv_num;
  logic [27:0] dv_den;
  logic        dv_done;
  logic [47:0] dv_quo;
  logic [27:0] dv_rem;

  grc_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo), .rem(dv_rem)
  );

  // working registers
  logic [10:0]        w_c, h_c;
  logic [9:0]         col;
  logic signed [25:0] cam;
  logic signed [41:0] prod_x, prod_y;
  logic signed [27:0] rx, ry;
  logic [40:0]        dx, dy;
  logic [47:0]        sdx, sdy;
  logic [51:0]        mulx, muly;
  logic signed [8:0]  mx, my;
  logic               side;
  logic               hit;
  logic [7:0]         tile;
  logic [7:0]         n;
  logic [23:0]        wall_dist;
  logic [9:0]         height;
  logic signed [45:0] numro;
  logic [9:0]         frac_base;
  logic [9:0]         first_r, last_r;
  logic [5:0]         tex;

  // absolute values of the ray
  logic [26:0] arx, ary;
  assign arx = rx[27] ? 27'(-rx) : 27'(rx);
  assign ary = ry[27] ? 27'(-ry) : 27'(ry);

  logic signed [27:0] rd, ro;
  assign rd = side ? ry : rx;
  assign ro = side ? rx : ry;
  logic [26:0] ard;
  assign ard = side ? ary : arx;

  // next dda step from side distances
  logic               step_x;
  logic signed [8:0]  nmx, nmy;
  logic               outside;
  assign step_x  = (sdx < sdy);
  assign nmx     = step_x ? (rx[27] ? mx - 9'sd1 : mx + 9'sd1) : mx;
  assign nmy     = step_x ? my : (ry[27] ? my - 9'sd1 : my + 9'sd1);
  assign outside = nmx < 0 || nmx >= MAP_SIZE || nmy < 0 || nmy >= MAP_SIZE;

  // numerator of the hit line distance, q.10
  logic signed [17:0] num_c;
  assign num_c = side
      ? (18'(my) * 18'sd1024 - $signed({2'b0, pos_y}) + (ry[27] ? 18'sd1024 : 18'sd0))
      : (18'(mx) * 18'sd1024 - $signed({2'b0, pos_x}) + (rx[27] ? 18'sd1024 : 18'sd0));
  logic [17:0] anum;
  assign anum = num_c[17] ? 18'(-num_c) : 18'(num_c);

  logic [45:0] anumro;
  assign anumro = numro[45] ? 46'(-numro) : 46'(numro);

  logic [10:0] h_ext;
  logic signed [12:0] start_v, end_v;
  assign start_v = ($signed({2'b0, h_c}) - $signed({3'b0, height})) >>> 1;
  assign end_v   = 13'((14'({3'b0, h_c}) + 14'(height)) >> 1);
  assign h_ext   = h_c - 11'd1;

  always_comb begin
    ram_we    = (state == S_CLEAR) || (state == S_IDLE && job_valid && !job.is_cast);
    ram_waddr = (state == S_CLEAR) ? clr_cnt[ADDR_BITS-1:0] : job.addr;
    ram_wdata = (state == S_CLEAR) ? 8'd0 : job.tile;
    ram_raddr = {my[MAP_BITS-1:0], mx[MAP_BITS-1:0]};
    job_take  = (state == S_IDLE) && job_valid;
  end

  always_comb begin
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    case (state)
      S_CAM: begin
        dv_start = 1'b1;
        dv_num = 48'({col, 15'b0});
        dv_den = 28'(w_c);
      end
      S_DLX: begin
        dv_start = (rx != 0);
        dv_num = 48'(1) << 30;
        dv_den = 28'(arx);
      end
      S_DLY: begin
        dv_start = (ry != 0);
        dv_num = 48'(1) << 30;
        dv_den = 28'(ary);
      end
      S_DIST: begin
        dv_start = (rd != 0);
        dv_num = 48'({anum, 20'b0});
        dv_den = 28'(ard);
      end
      S_HGT: begin
        dv_start = (wall_dist != 0);
        dv_num = 48'({h_c, 16'b0});
        dv_den = 28'(wall_dist);
      end
      S_TEX: begin
        dv_start = (rd != 0);
        dv_num = 48'(anumro);
        dv_den = 28'(ard);
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (ADDR_BITS+1)'(MAP_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (job_valid && job.is_cast) begin
            w_c   <= (view_w == 0) ? 11'd1 : (view_w > MAX_VIEW) ? 11'(MAX_VIEW) : view_w;
            h_c   <= (view_h == 0) ? 11'd1 : (view_h > MAX_VIEW) ? 11'(MAX_VIEW) : view_h;
            col   <= job.column;
            state <= S_CAM;
          end
        end
        S_CAM: state <= S_CAMW;
        S_CAMW: begin
          if (dv_done) begin
            cam   <= $signed(dv_quo[25:0]) - 26'sd16384;
            state <= S_RAY;
          end
        end
        S_RAY: begin
          prod_x <= 42'(plane_x) * 42'(cam);
          prod_y <= 42'(plane_y) * 42'(cam);
          state  <= S_RAYB;
        end
        S_RAYB: begin
          rx    <= 28'(dir_x) + 28'(prod_x >>> 14);
          ry    <= 28'(dir_y) + 28'(prod_y >>> 14);
          mx    <= $signed({3'b0, pos_x[15:10]});
          my    <= $signed({3'b0, pos_y[15:10]});
          state <= S_DLX;
        end
        S_DLX: begin
          if (rx == 0) begin
            dx <= 41'(1) << 40;
            state <= S_DLY;
          end else begin
            state <= S_DLXW;
          end
        end
        S_DLXW: begin
          if (dv_done) begin
            dx <= 41'(dv_quo[30:0]);
            state <= S_DLY;
          end
        end
        S_DLY: begin
          if (ry == 0) begin
            dy <= 41'(1) << 40;
            state <= S_SD;
          end else begin
            state <= S_DLYW;
          end
        end
        S_DLYW: begin
          if (dv_done) begin
            dy <= 41'(dv_quo[30:0]);
            state <= S_SD;
          end
        end
        S_SD: begin
          mulx  <= 52'(rx[27] ? {1'b0, pos_x[9:0]} : 11'd1024 - {1'b0, pos_x[9:0]}) * 52'(dx);
          muly  <= 52'(ry[27] ? {1'b0, pos_y[9:0]} : 11'd1024 - {1'b0, pos_y[9:0]}) * 52'(dy);
          state <= S_SDB;
        end
        S_SDB: begin
          sdx  <= 48'(mulx >> 10);
          sdy  <= 48'(muly >> 10);
          side <= 1'b0;
          tile <= 8'd0;
          hit  <= 1'b0;
          n    <= '0;
          state <= (pos_x[15:10] < MAP_SIZE && pos_y[15:10] < MAP_SIZE) ? S_STEP : S_DIST;
        end
        S_STEP: begin
          if (step_x) begin
            sdx  <= sdx + 48'(dx);
            side <= 1'b0;
          end else begin
            sdy  <= sdy + 48'(dy);
            side <= 1'b1;
          end
          mx <= nmx;
          my <= nmy;
          n  <= n + 8'd1;
          if (outside) begin
            tile  <= 8'd0;
            state <= S_DIST;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          tile <= ram_rdata;
          hit  <= (ram_rdata != 0);
          state <= (ram_rdata != 0 || n == 8'(WALK_MAX)) ? S_DIST : S_STEP;
        end
        S_DIST: begin
          if (rd == 0) begin
            wall_dist <= 24'hFFFFFF;
            state     <= S_HGT;
          end else begin
            state <= S_DISTW;
          end
        end
        S_DISTW: begin
          if (dv_done) begin
            wall_dist <= (dv_quo > 48'hFFFFFF) ? 24'hFFFFFF : dv_quo[23:0];
            state     <= S_HGT;
          end
        end
        S_HGT: begin
          numro <= 46'(num_c) * 46'(ro);
          frac_base <= side ? pos_x[9:0] : pos_y[9:0];
          if (wall_dist == 0) begin
            height <= 10'd1023;
            state  <= S_TEX;
          end else begin
            state <= S_HGTW;
          end
        end
        S_HGTW: begin
          if (dv_done) begin
            height <= (dv_quo > 48'd1023) ? 10'd1023 : dv_quo[9:0];
            state  <= S_TEX;
          end
        end
        S_TEX: begin
          if (rd == 0) begin
            tex   <= 6'(20'(frac_base) * TEX_SIZE >> 10);
            state <= S_ROWS;
          end else begin
            state <= S_TEXW;
          end
        end
        S_TEXW: begin
          if (dv_done) begin
            // floor toward minus infinity when the signs differ
            if ((numro[45] != rd[27]) && dv_rem != 0) begin
              tex <= 6'((20'(10'(frac_base - dv_quo[9:0] - 10'd1)) * TEX_SIZE) >> 10);
            end else if (numro[45] != rd[27]) begin
              tex <= 6'((20'(10'(frac_base - dv_quo[9:0])) * TEX_SIZE) >> 10);
            end else begin
              tex <= 6'((20'(10'(frac_base + dv_quo[9:0])) * TEX_SIZE) >> 10);
            end
            state <= S_ROWS;
          end
        end
        S_ROWS: begin
          first_r <= start_v[12] ? 10'd0 : (start_v > 13'sd1023) ? 10'd1023 : start_v[9:0];
          last_r  <= (end_v >= $signed({2'b0, h_c})) ? ((h_ext > 11'd1023) ? 10'd1023 : h_ext[9:0])
                   : (end_v > 13'sd1023) ? 10'd1023 : end_v[9:0];
          if ((!side && !rx[27] && rx != 0) || (side && ry[27])) begin
            tex <= 6'(TEX_SIZE - 1) - tex;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.hit         <= hit;
            out_data.side        <= side;
            out_data.tile_out    <= tile;
            out_data.hit_x       <= 6'(mx);
            out_data.hit_y       <= 6'(my);
            out_data.distance    <= wall_dist;
            out_data.wall_height <= height;
            out_data.first_row   <= first_r;
            out_data.last_row    <= last_r;
            out_data.tex_column  <= tex;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/grid_raycast_column.sv
// grid_raycast_column: top level, register file plus front and back parts
// depends on grc_pkg, grc_if, grc_front, grc_back
//
//  channel  dir  beat carries
//  in       in   mode, cell_x, cell_y, tile_in, column
//  out      out  hit, side, tile_out, hit_x, hit_y, distance, wall_height, rows, tex
//  cfg      in   index, wdata
//
// a cast lasts longer for every visited cell and uses the shared 48-step divider
// up to six times per column
// after reset a clearing pass over all 4096 cells empties the map; no cast runs meanwhile
// a stalled result holds in the output register while the queue keeps filling
`timescale 1ns / 1ps
module grid_raycast_column import grc_pkg::*; (
  input logic      clk,
  input logic      rst,
  grc_in_if.sink   in_ch,
  grc_out_if.source out_ch,
  grc_cfg_if.sink  cfg
);
  logic [15:0]        pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;
  logic [10:0]        view_w, view_h;
  logic               job_valid;
  logic               job_take;
  job_t               job;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0; pos_y <= '0;
      dir_x <= '0; dir_y <= '0; plane_x <= '0; plane_y <= '0;
      view_w <= 11'd320; view_h <= 11'd240;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_POS_X:   pos_x   <= cfg.wdata;
        REG_POS_Y:   pos_y   <= cfg.wdata;
        REG_DIR_X:   dir_x   <= cfg.wdata;
        REG_DIR_Y:   dir_y   <= cfg.wdata;
        REG_PLANE_X: plane_x <= cfg.wdata;
        REG_PLANE_Y: plane_y <= cfg.wdata;
        REG_VIEW_W:  view_w  <= cfg.wdata[10:0];
        REG_VIEW_H:  view_h  <= cfg.wdata[10:0];
        default: begin
        end
      endcase
    end
  end

  grc_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .job_valid(job_valid), .job_take(job_take), .job(job)
  );

  grc_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_take(job_take), .job(job),
    .pos_x(pos_x), .pos_y(pos_y), .dir_x(dir_x), .dir_y(dir_y),
    .plane_x(plane_x), .plane_y(plane_y), .view_w(view_w), .view_h(view_h),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule
